// ----- src/itkf_pkg.sv -----
// Shared constants and helpers for the IMU tilt Kalman filter.
package itkf_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CordicN   = 17;

  localparam logic [CfgIdxW-1:0] REG_ACCEL_BIAS_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ACCEL_BIAS_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ACCEL_BIAS_Z  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GYRO_BIAS_X   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GYRO_BIAS_Y   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GYRO_BIAS_Z   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MEASURE_NOISE = 3'd7;

  localparam logic [30:0] ProcessNoiseRst = 31'd655;
  localparam logic [30:0] MeasureNoiseRst = 31'd6553600;
  localparam logic [30:0] VarianceRst     = 31'd655;
  localparam logic signed [31:0] HalfPi   = 32'sd102944;
  localparam logic [30:0] Var31Max        = 31'h7FFF_FFFF;
  localparam logic [16:0] GainOne         = 17'h1_0000;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -40'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [16:0] atan_tab(input logic [4:0] i);
    logic [16:0] r;
    unique case (i)
      5'd0:  r = 17'd51472;
      5'd1:  r = 17'd30386;
      5'd2:  r = 17'd16055;
      5'd3:  r = 17'd8150;
      5'd4:  r = 17'd4091;
      5'd5:  r = 17'd2047;
      5'd6:  r = 17'd1024;
      5'd7:  r = 17'd512;
      5'd8:  r = 17'd256;
      5'd9:  r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/itkf_in_if.sv -----
// Input channel: one IMU sample word with valid/ready.
interface itkf_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] accel_z;
  logic signed [31:0] world_accel_y;
  logic signed [31:0] world_accel_z;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;
  logic [19:0]        step_time;

  modport source (output valid, func, accel_x, accel_y, accel_z, world_accel_y,
                  world_accel_z, rate_x, rate_y, rate_z, step_time, input ready);
  modport sink   (input valid, func, accel_x, accel_y, accel_z, world_accel_y,
                  world_accel_z, rate_x, rate_y, rate_z, step_time, output ready);
endinterface

// ----- src/itkf_out_if.sv -----
// Output channel: one roll/pitch/yaw estimate word with valid/ready.
interface itkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll_out;
  logic signed [31:0] pitch_out;
  logic signed [31:0] yaw_out;

  modport source (output valid, roll_out, pitch_out, yaw_out, input ready);
  modport sink   (input valid, roll_out, pitch_out, yaw_out, output ready);
endinterface

// ----- src/imu_tilt_kalman_filter.sv -----
// IMU tilt Kalman filter top level: sequencer over shared multiplier, sqrt, CORDIC, divider.
//
// in_i takes one sample word when valid and ready are high. func 0 loads the
// roll/pitch/yaw estimates from accel_x/y/z; func 1 runs bias removal, the
// tilt measurement (isqrt + two CORDIC atan2) and three scalar Kalman updates.
// out_o returns one word with the three estimates for every input word.
// A load word goes from the idle state straight to the output state; a
// predict word passes through the squares, the square root, the two
// CORDIC passes, the three axis updates, each with a gain division, and
// the output state. The shared multiplier and the one-bit-per-cycle
// sqrt/CORDIC/divider set the length of this sequence. in_i.ready
// is high only while the sequencer is idle. The output register holds one
// finished word; if the receiver stalls, the next word is still accepted and
// computed, then waits in the final state until the output register frees up.
// Reset clears the estimates to 0, the variances to 655, the biases to 0 and
// the noise registers to 655 and 6553600. cfg_we_i writes register cfg_idx_i
// and should only be used while the block is idle.
module imu_tilt_kalman_filter import itkf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  itkf_in_if.sink             in_i,
  itkf_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAG_A = 4'd1;
  localparam logic [3:0] S_MAG_B = 4'd2;
  localparam logic [3:0] S_MAG_C = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CITER = 4'd6;
  localparam logic [3:0] S_AXMUL = 4'd7;
  localparam logic [3:0] S_AXINT = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_AXM2  = 4'd10;
  localparam logic [3:0] S_AXM3  = 4'd11;
  localparam logic [3:0] S_AXWR  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_q;

  // configuration
  logic signed [31:0] abias_q [3];
  logic signed [31:0] gbias_q [3];
  logic [30:0]        qn_q, rn_q;

  // filter state
  logic signed [31:0] est_q [3];
  logic [30:0]        var_q [3];

  // sample, bias removed
  logic signed [31:0] ax_q, ay_q, az_q, wy_q, wz_q;
  logic signed [31:0] rate_q [3];
  logic [19:0]        dt_q;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_d, prod_q;

  // sqrt
  logic [63:0] sq_n_q, sq_res_q, sq_bit_q, mag_q, sq_t;

  // cordic
  logic signed [35:0] cx_q, cy_q, cx_sh, cy_sh, cxin, cyin;
  logic signed [31:0] cang_q, cang_d;
  logic               cz_q, csel_q;
  logic signed [31:0] meas_q [2];
  logic [4:0]         cnt_q;

  // axis update
  logic [1:0]         k_q;
  logic signed [31:0] et_q, meas_k;
  logic [30:0]        p_q;
  logic [32:0]        den_q;
  logic [33:0]        rem_q, div_t;
  logic [16:0]        gain_q;
  logic               div_ge;
  logic [31:0]        psum;
  logic [30:0]        p_new;

  // output register
  logic               ovalid_q;
  logic signed [31:0] oroll_q, opitch_q, oyaw_q;

  logic in_fire, out_fire, out_load;

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_fire      = ovalid_q && out_o.ready;
  assign out_load      = (state_q == S_OUT) && (!ovalid_q || out_o.ready);
  assign out_o.valid     = ovalid_q;
  assign out_o.roll_out  = oroll_q;
  assign out_o.pitch_out = opitch_q;
  assign out_o.yaw_out   = oyaw_q;

  function automatic logic signed [31:0] bsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(40'(a) - 40'(b));
  endfunction

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MAG_A: begin mul_a = 34'(ay_q); mul_b = 34'(ay_q); end
      S_MAG_B: begin mul_a = 34'(az_q); mul_b = 34'(az_q); end
      S_AXMUL: begin mul_a = 34'(rate_q[k_q]); mul_b = {14'b0, dt_q}; end
      S_AXM2:  begin mul_a = {17'b0, gain_q}; mul_b = 34'(meas_k) - 34'(et_q); end
      S_AXM3:  begin mul_a = {3'b0, p_q}; mul_b = {17'b0, 17'(GainOne - gain_q)}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  assign meas_k = (k_q == 2'd2) ? est_q[2] : meas_q[k_q[0]];

  assign sq_t = sq_res_q + sq_bit_q;

  assign cx_sh = cx_q >>> cnt_q;
  assign cy_sh = cy_q >>> cnt_q;
  assign cang_d = (cy_q > 36'sd0) ? cang_q + $signed({15'b0, atan_tab(cnt_q)})
                                  : cang_q - $signed({15'b0, atan_tab(cnt_q)});

  assign cyin = csel_q ? 36'(ax_q) : -36'(wy_q);
  assign cxin = csel_q ? {4'b0, sq_res_q[31:0]} : -36'(wz_q);

  assign div_t  = (cnt_q == 5'd0) ? rem_q : {rem_q[32:0], 1'b0};
  assign div_ge = div_t >= {1'b0, den_q};

  assign psum  = {1'b0, var_q[k_q]} + {1'b0, qn_q};
  assign p_new = psum[31] ? Var31Max : psum[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abias_q  <= '{default: '0};
      gbias_q  <= '{default: '0};
      qn_q     <= ProcessNoiseRst;
      rn_q     <= MeasureNoiseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACCEL_BIAS_X:  abias_q[0] <= cfg_data_i;
        REG_ACCEL_BIAS_Y:  abias_q[1] <= cfg_data_i;
        REG_ACCEL_BIAS_Z:  abias_q[2] <= cfg_data_i;
        REG_GYRO_BIAS_X:   gbias_q[0] <= cfg_data_i;
        REG_GYRO_BIAS_Y:   gbias_q[1] <= cfg_data_i;
        REG_GYRO_BIAS_Z:   gbias_q[2] <= cfg_data_i;
        REG_PROCESS_NOISE: qn_q <= cfg_data_i[30:0];
        REG_MEASURE_NOISE: rn_q <= cfg_data_i[30:0];
        default:           qn_q <= qn_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      est_q    <= '{default: '0};
      var_q    <= '{default: VarianceRst};
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      k_q      <= '0;
      csel_q   <= 1'b0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (out_fire) ovalid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (!in_i.func) begin
              est_q[0] <= in_i.accel_x;
              est_q[1] <= in_i.accel_y;
              est_q[2] <= in_i.accel_z;
              state_q  <= S_OUT;
            end else begin
              state_q  <= S_MAG_A;
            end
          end
        end
        S_MAG_A: state_q <= S_MAG_B;
        S_MAG_B: state_q <= S_MAG_C;
        S_MAG_C: state_q <= S_SQRT;
        S_SQRT: begin
          if (sq_bit_q == 64'd1) begin
            csel_q  <= 1'b0;
            state_q <= S_CINIT;
          end
        end
        S_CINIT: begin
          cnt_q   <= '0;
          state_q <= S_CITER;
        end
        S_CITER: begin
          if (cnt_q == 5'(CordicN - 1)) begin
            if (csel_q) begin
              k_q     <= '0;
              state_q <= S_AXMUL;
            end else begin
              csel_q  <= 1'b1;
              state_q <= S_CINIT;
            end
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_AXMUL: state_q <= S_AXINT;
        S_AXINT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == 5'd16) state_q <= S_AXM2;
          else cnt_q <= cnt_q + 5'd1;
        end
        S_AXM2: state_q <= S_AXM3;
        S_AXM3: begin
          est_q[k_q] <= sat32(40'(et_q) + 40'(prod_q >>> 16));
          state_q    <= S_AXWR;
        end
        S_AXWR: begin
          var_q[k_q] <= prod_q[46:16];
          if (k_q == 2'd2) begin
            state_q <= S_OUT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_AXMUL;
          end
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q      <= bsub(in_i.accel_x, abias_q[0]);
      ay_q      <= bsub(in_i.accel_y, abias_q[1]);
      az_q      <= bsub(in_i.accel_z, abias_q[2]);
      wy_q      <= bsub(in_i.world_accel_y, abias_q[1]);
      wz_q      <= bsub(in_i.world_accel_z, abias_q[2]);
      rate_q[0] <= bsub(in_i.rate_x, gbias_q[0]);
      rate_q[1] <= bsub(in_i.rate_y, gbias_q[1]);
      rate_q[2] <= bsub(in_i.rate_z, gbias_q[2]);
      dt_q      <= in_i.step_time;
    end
    if (state_q == S_MAG_B) mag_q <= prod_q[63:0];
    if (state_q == S_MAG_C) begin
      sq_n_q   <= mag_q + prod_q[63:0];
      sq_res_q <= '0;
      sq_bit_q <= 64'd1 << 62;
    end
    if (state_q == S_SQRT) begin
      if (sq_n_q >= sq_t) begin
        sq_n_q   <= sq_n_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (state_q == S_CINIT) begin
      cz_q <= (cxin == 36'sd0) && (cyin == 36'sd0);
      if (cxin < 36'sd0) begin
        if (cyin >= 36'sd0) begin
          cx_q <= cyin; cy_q <= -cxin; cang_q <= HalfPi;
        end else begin
          cx_q <= -cyin; cy_q <= cxin; cang_q <= -HalfPi;
        end
      end else begin
        cx_q <= cxin; cy_q <= cyin; cang_q <= '0;
      end
    end
    if (state_q == S_CITER) begin
      if (cy_q > 36'sd0) begin
        cx_q <= cx_q + cy_sh;
        cy_q <= cy_q - cx_sh;
      end else begin
        cx_q <= cx_q - cy_sh;
        cy_q <= cy_q + cx_sh;
      end
      cang_q <= cang_d;
      if (cnt_q == 5'(CordicN - 1)) meas_q[csel_q] <= cz_q ? 32'sd0 : cang_d;
    end
    if (state_q == S_AXINT) begin
      et_q   <= sat32(40'(est_q[k_q]) + 40'(prod_q >>> 16));
      p_q    <= p_new;
      den_q  <= {2'b0, p_new} + {2'b0, rn_q};
      rem_q  <= {3'b0, p_new};
      gain_q <= '0;
    end
    if (state_q == S_DIV) begin
      if (div_ge) rem_q <= div_t - {1'b0, den_q};
      else rem_q <= div_t;
      gain_q <= (den_q == 33'd0) ? 17'd0 : {gain_q[15:0], div_ge};
    end
    if (out_load) begin
      oroll_q  <= est_q[0];
      opitch_q <= est_q[1];
      oyaw_q   <= est_q[2];
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after accepting a word");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AXM2) |-> gain_q <= GainOne)
    else $error("Kalman gain above one");

  a_sqrt_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CINIT) |-> sq_res_q[63:32] == 32'd0)
    else $error("square root wider than 32 bits");

endmodule
